// ===== rtl/deq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// shared types and codes for the double-ended queue core: request and
// response items, request kinds, status codes and controller states
// ----------------------------------------------------------------------------
package deq_pkg;

   // request kinds
   localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
   localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
   localparam logic [2:0] KIND_POP_BACK   = 3'd3;
   localparam logic [2:0] KIND_WALK       = 3'd4;

   // response status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   // a walk emits at most this many items
   localparam int MAX_RESULTS = 16;
   localparam int WALK_W      = $clog2(MAX_RESULTS);

   typedef struct packed {
      logic [2:0]         kind;
      logic signed [31:0] value;
   } deq_req_type;

   typedef struct packed {
      logic signed [31:0] item;
      logic [1:0]         status;
      logic [4:0]         occupancy;
      logic               final_res;
   } deq_rsp_type;

   // pointer updates requested by the controller
   typedef struct packed {
      logic push_front;
      logic push_back;
      logic pop_front;
      logic pop_back;
   } deq_op_type;

   // fill flags reported by the pointer unit
   typedef struct packed {
      logic empty;
      logic full;
   } deq_flags_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_POP_WAIT,
      S_WALK
   } deq_state_type;

endpackage

// ===== rtl/double_ended_queue_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_core
// bounded double-ended queue of signed 32-bit values in a ring ram
//
//   channel   ports                      direction  handshake
//   request   start, busy, req_data      in         taken when start && !busy
//   response  rsp_valid, rsp_data        out        one-cycle strobe, no stall
//
// push, error and unknown requests finish in the cycle they are taken; the
// response is registered and appears in the next cycle.
// a pop reads the ring ram when taken and waits in S_POP_WAIT for the registered
// read data; a walk emits up to 16 items from the front, each read from the
// ring ram; busy stays high until the last item is issued.
// reset clears front pointer, fill count and controller; no ram clearing.
// the receiver cannot stall, so responses never back up.
// ----------------------------------------------------------------------------
module double_ended_queue_core #(
   parameter int DEPTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  deq_pkg::deq_req_type req_data,
   output logic                 rsp_valid,
   output deq_pkg::deq_rsp_type rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   deq_pkg::deq_state_type state_ff, state_in;
   deq_pkg::deq_op_type    op;
   deq_pkg::deq_flags_type flags;
   deq_pkg::deq_rsp_type   rsp_data_ff, rsp_data_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [AW-1:0]              walk_addr_ff, walk_addr_in;
   logic [deq_pkg::WALK_W-1:0] walk_left_ff, walk_left_in;
   logic [AW-1:0]              walk_addr_inc;

   logic [AW-1:0]  front, front_dec, back_wr, back_rd;
   logic [CW-1:0]  count;
   logic           accept;
   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   logic [31:0]    wr_data;
   logic [AW-1:0]  rd_addr;
   logic [31:0]    rd_data;

   deq_ptr #(
      .DEPTH(DEPTH)
   ) u_ptr (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .front     (front),
      .front_dec (front_dec),
      .back_wr   (back_wr),
      .back_rd   (back_rd),
      .count     (count),
      .flags     (flags)
   );

   deq_ram #(
      .WIDTH(32),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy          = (state_ff != deq_pkg::S_IDLE);
   assign accept        = start && !busy;
   assign walk_addr_inc = (walk_addr_ff == AW'(DEPTH - 1)) ? '0 : walk_addr_ff + AW'(1);

   // next state: pops and walks only read the ram and later requests wait for
   // busy, so no push writes the ram while a pop or walk read is outstanding
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         deq_pkg::S_IDLE: begin
            if (accept) begin
               if ((req_data.kind inside {deq_pkg::KIND_POP_FRONT, deq_pkg::KIND_POP_BACK})
                   && !flags.empty) begin
                  state_in = deq_pkg::S_POP_WAIT;
               end else if (req_data.kind == deq_pkg::KIND_WALK && !flags.empty) begin
                  state_in = deq_pkg::S_WALK;
               end
            end
         end
         deq_pkg::S_POP_WAIT: begin
            state_in = deq_pkg::S_IDLE;
         end
         deq_pkg::S_WALK: begin
            if (walk_left_ff == '0) begin
               state_in = deq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = deq_pkg::S_IDLE;
         end
      endcase
   end

   // outputs: ram access, pointer update and the next response item
   always_comb begin
      op           = '0;
      wr_en        = 1'b0;
      wr_addr      = back_wr;
      wr_data      = req_data.value;
      rd_addr      = front;
      walk_addr_in = walk_addr_ff;
      walk_left_in = walk_left_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = '0;
      case (state_ff)
         deq_pkg::S_IDLE: begin
            if (accept) begin
               rsp_data_in.final_res = 1'b1;
               rsp_data_in.occupancy = 5'(count);
               case (req_data.kind)
                  deq_pkg::KIND_PUSH_FRONT, deq_pkg::KIND_PUSH_BACK: begin
                     rsp_valid_in = 1'b1;
                     if (flags.full) begin
                        rsp_data_in.status = deq_pkg::STATUS_FULL;
                     end else begin
                        wr_en                 = 1'b1;
                        op.push_front         = (req_data.kind == deq_pkg::KIND_PUSH_FRONT);
                        op.push_back          = (req_data.kind == deq_pkg::KIND_PUSH_BACK);
                        wr_addr               = op.push_front ? front_dec : back_wr;
                        rsp_data_in.occupancy = 5'(count) + 5'd1;
                     end
                  end
                  deq_pkg::KIND_POP_FRONT, deq_pkg::KIND_POP_BACK: begin
                     if (flags.empty) begin
                        rsp_valid_in       = 1'b1;
                        rsp_data_in.status = deq_pkg::STATUS_EMPTY;
                     end else begin
                        op.pop_front = (req_data.kind == deq_pkg::KIND_POP_FRONT);
                        op.pop_back  = (req_data.kind == deq_pkg::KIND_POP_BACK);
                        rd_addr      = op.pop_front ? front : back_rd;
                     end
                  end
                  deq_pkg::KIND_WALK: begin
                     if (flags.empty) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        rd_addr      = front;
                        walk_addr_in = front;
                        if (int'(count) > deq_pkg::MAX_RESULTS) begin
                           walk_left_in = deq_pkg::WALK_W'(deq_pkg::MAX_RESULTS - 1);
                        end else begin
                           walk_left_in = deq_pkg::WALK_W'(count - CW'(1));
                        end
                     end
                  end
                  default: begin
                     // unknown kind: state untouched, plain acknowledge
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         deq_pkg::S_POP_WAIT: begin
            // count already reflects the pop
            rsp_valid_in          = 1'b1;
            rsp_data_in.item      = rd_data;
            rsp_data_in.occupancy = 5'(count);
            rsp_data_in.final_res = 1'b1;
         end
         deq_pkg::S_WALK: begin
            // emit the entry read last cycle and fetch the next one
            rsp_valid_in          = 1'b1;
            rsp_data_in.item      = rd_data;
            rsp_data_in.occupancy = 5'(count);
            rsp_data_in.final_res = (walk_left_ff == '0);
            rd_addr               = walk_addr_inc;
            if (walk_left_ff != '0) begin
               walk_addr_in = walk_addr_inc;
               walk_left_in = walk_left_ff - deq_pkg::WALK_W'(1);
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= deq_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      walk_addr_ff <= walk_addr_in;
      walk_left_ff <= walk_left_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/deq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ram
// generic single-write, single-read synchronous ram with registered read
// ----------------------------------------------------------------------------
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/deq_ptr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ptr
// front pointer and fill count of the ring, with the wrapped addresses of
// both ends for the next access
// ----------------------------------------------------------------------------
module deq_ptr #(
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  deq_pkg::deq_op_type        op,
   output logic [$clog2(DEPTH)-1:0]   front,
   output logic [$clog2(DEPTH)-1:0]   front_dec,
   output logic [$clog2(DEPTH)-1:0]   back_wr,
   output logic [$clog2(DEPTH)-1:0]   back_rd,
   output logic [$clog2(DEPTH+1)-1:0] count,
   output deq_pkg::deq_flags_type     flags
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = $clog2(2 * DEPTH);

   logic [AW-1:0] front_ff, front_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] front_inc;
   logic [SW-1:0] sum;
   logic [SW-1:0] sum_m1;

   // wrapped neighbors of the front
   always_comb begin
      front_inc = (front_ff == AW'(DEPTH - 1)) ? '0 : front_ff + AW'(1);
      front_dec = (front_ff == '0) ? AW'(DEPTH - 1) : front_ff - AW'(1);
   end

   // back addresses: sum stays below twice the depth, one subtract wraps it
   always_comb begin
      sum     = SW'(front_ff) + SW'(count_ff);
      sum_m1  = sum - SW'(1);
      back_wr = (sum >= SW'(DEPTH)) ? AW'(sum - SW'(DEPTH)) : AW'(sum);
      back_rd = (sum_m1 >= SW'(DEPTH)) ? AW'(sum_m1 - SW'(DEPTH)) : AW'(sum_m1);
   end

   // pointer and count update
   always_comb begin
      front_in = front_ff;
      count_in = count_ff;
      if (op.push_front) begin
         front_in = front_dec;
         count_in = count_ff + CW'(1);
      end else if (op.push_back) begin
         count_in = count_ff + CW'(1);
      end else if (op.pop_front) begin
         front_in = front_inc;
         count_in = count_ff - CW'(1);
      end else if (op.pop_back) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   assign front       = front_ff;
   assign count       = count_ff;
   assign flags.empty = (count_ff == '0);
   assign flags.full  = (count_ff == CW'(DEPTH));

endmodule
